@@ rtl/paged_memory_allocator_translator_unit_assert.svh @@
// Assertion macros for the allocator/translator RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef PAGED_MEMORY_ALLOCATOR_TRANSLATOR_UNIT_ASSERT_SVH
`define PAGED_MEMORY_ALLOCATOR_TRANSLATOR_UNIT_ASSERT_SVH

// same-cycle implication
`define PMAT_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PMAT_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/pmat_pkg.sv @@
// Package for the paged memory allocator/translator: beat types, codes, defaults.
// No dependencies.
package pmat_pkg;

    localparam int OFFSET_BITS_DEF    = 8;
    localparam int NUM_PAGES_DEF      = 64;
    localparam int TABLE_PTR_BASE_DEF = 64;

    localparam int PHYS_ADDR_W = 14;

    typedef enum logic [1:0] {
        ACT_NEW   = 2'd0,
        ACT_KILL  = 2'd1,
        ACT_STORE = 2'd2,
        ACT_LOAD  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_TABLE = 2'd1,
        ST_NO_DATA  = 2'd2,
        ST_FAULT    = 2'd3
    } status_t;

    typedef struct packed {
        action_t     action;
        logic [5:0]  process_id;
        logic [6:0]  pages_wanted;
        logic [15:0] virtual_addr;
        logic [7:0]  write_byte;
    } req_t;

    typedef struct packed {
        status_t                status;
        logic [PHYS_ADDR_W-1:0] phys_addr;
        logic [7:0]             read_byte;
    } rsp_t;

    typedef struct packed {
        logic       en;
        logic       we;
        logic [7:0] wdata;
    } mem_cmd_t;

endpackage

@@ rtl/pmat_ram.sv @@
// Single-port byte RAM holding physical memory, registered read data.
// Depends on pmat_pkg.
module pmat_ram
    import pmat_pkg::*;
#(
    parameter int DEPTH = NUM_PAGES_DEF << OFFSET_BITS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  mem_cmd_t      cmd,
    input  logic [AW-1:0] addr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.en)
        begin
            if (cmd.we)
            begin
                mem[addr] <= cmd.wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/pmat_seq.sv @@
// Sequencer: clearing pass, first-fit page scan, table walk and translation,
// all through the one RAM port. Depends on pmat_pkg and the assert macro header.
`include "paged_memory_allocator_translator_unit_assert.svh"

module pmat_seq
    import pmat_pkg::*;
#(
    parameter int OFFSET_BITS    = OFFSET_BITS_DEF,
    parameter int NUM_PAGES      = NUM_PAGES_DEF,
    parameter int TABLE_PTR_BASE = TABLE_PTR_BASE_DEF,
    parameter int AW             = $clog2(NUM_PAGES << OFFSET_BITS)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  req_t          req,
    output logic          res_valid,
    input  logic          res_ready,
    output rsp_t          res,
    output mem_cmd_t      cmd,
    output logic [AW-1:0] mem_addr,
    input  logic [7:0]    rdata
);

    localparam int MEM_BYTES  = NUM_PAGES << OFFSET_BITS;
    localparam int PAGE_BYTES = 1 << OFFSET_BITS;
    localparam int PGW        = $clog2(NUM_PAGES);
    localparam int SW         = PGW + 1;
    localparam int CW         = OFFSET_BITS + 1;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_PTR_WR,
        S_ALLOC,
        S_ENT_WR,
        S_PTR_RD,
        S_PTR_CHK,
        S_WALK_RD,
        S_WALK_CHK,
        S_FREE_TP,
        S_PTE_RD,
        S_PTE_CHK,
        S_LOAD,
        S_DONE
    } state_t;

    state_t        state_reg, state_next;
    req_t          item_reg, item_next;
    logic [7:0]    tp_reg, tp_next;
    logic [SW-1:0] scan_reg, scan_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] want_reg, want_next;
    logic [AW-1:0] pa_reg, pa_next;
    status_t       status_reg, status_next;
    logic [7:0]    rb_reg, rb_next;
    logic          tbl_reg, tbl_next;
    logic [AW-1:0] clr_reg, clr_next;

    logic [AW-1:0] ptr_addr;
    logic [AW-1:0] ent_addr;
    logic [AW-1:0] pte_addr;
    logic [AW-1:0] pa_rd;
    logic [15:0]   vpage;
    logic          vp_ok;
    logic          pg_ok;
    logic [SW-1:0] found;

    assign ptr_addr = AW'(TABLE_PTR_BASE) + AW'(item_reg.process_id);
    assign ent_addr = AW'({tp_reg[PGW-1:0], cnt_reg[OFFSET_BITS-1:0]});
    assign vpage    = item_reg.virtual_addr >> OFFSET_BITS;
    assign vp_ok    = (17'(vpage) < 17'(PAGE_BYTES));
    assign pte_addr = AW'({tp_reg[PGW-1:0], vpage[OFFSET_BITS-1:0]});
    assign pa_rd    = AW'({rdata[PGW-1:0], item_reg.virtual_addr[OFFSET_BITS-1:0]});
    assign pg_ok    = ({1'b0, rdata} < 9'(NUM_PAGES));
    assign found    = scan_reg - SW'(1);

    assign req_ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res.status    = status_reg;
    assign res.phys_addr = PHYS_ADDR_W'(pa_reg);
    assign res.read_byte = rb_reg;

    always_comb
    begin
        state_next  = state_reg;
        item_next   = item_reg;
        tp_next     = tp_reg;
        scan_next   = scan_reg;
        cnt_next    = cnt_reg;
        want_next   = want_reg;
        pa_next     = pa_reg;
        status_next = status_reg;
        rb_next     = rb_reg;
        tbl_next    = tbl_reg;
        clr_next    = clr_reg;
        cmd         = '0;
        mem_addr    = '0;

        case (state_reg)
            S_CLEAR:
            begin
                cmd.en    = 1'b1;
                cmd.we    = 1'b1;
                cmd.wdata = (clr_reg == '0) ? 8'd1 : 8'd0;
                mem_addr  = clr_reg;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == AW'(MEM_BYTES - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    item_next   = req;
                    status_next = ST_OK;
                    pa_next     = '0;
                    rb_next     = '0;
                    scan_next   = '0;
                    tbl_next    = 1'b1;
                    cnt_next    = '0;
                    if (12'(req.pages_wanted) > 12'(PAGE_BYTES))
                    begin
                        want_next = CW'(PAGE_BYTES);
                    end
                    else
                    begin
                        want_next = CW'(req.pages_wanted);
                    end
                    state_next = (req.action == ACT_NEW) ? S_SCAN_RD : S_PTR_RD;
                end
            end
            S_SCAN_RD:
            begin
                if (scan_reg == SW'(NUM_PAGES))
                begin
                    status_next = tbl_reg ? ST_NO_TABLE : ST_NO_DATA;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.en     = 1'b1;
                    mem_addr   = AW'(scan_reg);
                    state_next = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK:
            begin
                scan_next = scan_reg + SW'(1);
                if (rdata == 8'd0)
                begin
                    cmd.en    = 1'b1;
                    cmd.we    = 1'b1;
                    cmd.wdata = 8'd1;
                    mem_addr  = AW'(scan_reg);
                    if (tbl_reg)
                    begin
                        tp_next    = 8'(scan_reg);
                        state_next = S_PTR_WR;
                    end
                    else
                    begin
                        state_next = S_ENT_WR;
                    end
                end
                else
                begin
                    state_next = S_SCAN_RD;
                end
            end
            S_PTR_WR:
            begin
                cmd.en     = 1'b1;
                cmd.we     = 1'b1;
                cmd.wdata  = tp_reg;
                mem_addr   = ptr_addr;
                tbl_next   = 1'b0;
                cnt_next   = '0;
                state_next = S_ALLOC;
            end
            S_ALLOC:
            begin
                state_next = (cnt_reg == want_reg) ? S_DONE : S_SCAN_RD;
            end
            S_ENT_WR:
            begin
                cmd.en     = 1'b1;
                cmd.we     = 1'b1;
                cmd.wdata  = 8'(found);
                mem_addr   = ent_addr;
                cnt_next   = cnt_reg + CW'(1);
                state_next = S_ALLOC;
            end
            S_PTR_RD:
            begin
                cmd.en     = 1'b1;
                mem_addr   = ptr_addr;
                state_next = S_PTR_CHK;
            end
            S_PTR_CHK:
            begin
                tp_next  = rdata;
                cnt_next = '0;
                if (item_reg.action == ACT_KILL)
                begin
                    state_next = pg_ok ? S_WALK_RD : S_FREE_TP;
                end
                else if (pg_ok && vp_ok)
                begin
                    state_next = S_PTE_RD;
                end
                else
                begin
                    status_next = ST_FAULT;
                    state_next  = S_DONE;
                end
            end
            S_WALK_RD:
            begin
                cmd.en     = 1'b1;
                mem_addr   = ent_addr;
                state_next = S_WALK_CHK;
            end
            S_WALK_CHK:
            begin
                // entry values are below 256, always inside memory
                if (rdata != 8'd0)
                begin
                    cmd.en    = 1'b1;
                    cmd.we    = 1'b1;
                    cmd.wdata = 8'd0;
                    mem_addr  = AW'(rdata);
                end
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg[OFFSET_BITS-1:0] == '1)
                begin
                    state_next = S_FREE_TP;
                end
                else
                begin
                    state_next = S_WALK_RD;
                end
            end
            S_FREE_TP:
            begin
                cmd.en     = 1'b1;
                cmd.we     = 1'b1;
                cmd.wdata  = 8'd0;
                mem_addr   = AW'(tp_reg);
                state_next = S_DONE;
            end
            S_PTE_RD:
            begin
                cmd.en     = 1'b1;
                mem_addr   = pte_addr;
                state_next = S_PTE_CHK;
            end
            S_PTE_CHK:
            begin
                if (!pg_ok)
                begin
                    status_next = ST_FAULT;
                    state_next  = S_DONE;
                end
                else
                begin
                    pa_next  = pa_rd;
                    cmd.en   = 1'b1;
                    mem_addr = pa_rd;
                    if (item_reg.action == ACT_STORE)
                    begin
                        cmd.we     = 1'b1;
                        cmd.wdata  = item_reg.write_byte;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_LOAD;
                    end
                end
            end
            S_LOAD:
            begin
                rb_next    = rdata;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_CLEAR;
            item_reg   <= '0;
            tp_reg     <= '0;
            scan_reg   <= '0;
            cnt_reg    <= '0;
            want_reg   <= '0;
            pa_reg     <= '0;
            status_reg <= ST_OK;
            rb_reg     <= '0;
            tbl_reg    <= 1'b0;
            clr_reg    <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            item_reg   <= item_next;
            tp_reg     <= tp_next;
            scan_reg   <= scan_next;
            cnt_reg    <= cnt_next;
            want_reg   <= want_next;
            pa_reg     <= pa_next;
            status_reg <= status_next;
            rb_reg     <= rb_next;
            tbl_reg    <= tbl_next;
            clr_reg    <= clr_next;
        end
    end

    `PMAT_ASSERT_NOW(a_scan_bound, clk, rst_n, 1'b1, scan_reg <= SW'(NUM_PAGES), "scan ran past map")
    `PMAT_ASSERT_NOW(a_addr_range, clk, rst_n, cmd.en, 32'(mem_addr) < MEM_BYTES, "RAM address beyond memory")
    `PMAT_ASSERT_NEXT(a_busy, clk, rst_n, req_valid && req_ready, !req_ready, "ready while busy")
    `PMAT_ASSERT_NEXT(a_release, clk, rst_n, res_valid && res_ready, req_ready, "not idle after result")
    `PMAT_ASSERT_NOW(a_fault_clean, clk, rst_n, res_valid && (res.status == ST_FAULT), (res.phys_addr == '0) && (res.read_byte == '0), "fault with data")

endmodule

@@ rtl/paged_memory_allocator_translator_unit.sv @@
// Paged memory allocator/translator: one request beat in, one response beat out.
// After reset, req_ready stays low for a clearing pass over all NUM_PAGES << OFFSET_BITS
// bytes that zeroes memory and marks page zero used. One request is worked at a time
// through a single-port byte RAM, one access per cycle: new process scans the map byte
// by byte (the scan only moves forward, so at most NUM_PAGES bytes) and writes each page
// taken; kill reads every table entry and frees its page, then the table page, and skips
// the walk when the table pointer lies beyond memory; store and load read the table
// pointer and the entry before the data access. The response sits in an output register,
// so the result of one request waits there while the next is worked.
// Depends on pmat_pkg, pmat_seq and pmat_ram.
module paged_memory_allocator_translator_unit
    import pmat_pkg::*;
#(
    parameter int OFFSET_BITS    = OFFSET_BITS_DEF,
    parameter int NUM_PAGES      = NUM_PAGES_DEF,
    parameter int TABLE_PTR_BASE = TABLE_PTR_BASE_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    localparam int MEM_BYTES = NUM_PAGES << OFFSET_BITS;
    localparam int AW        = $clog2(MEM_BYTES);

    mem_cmd_t      cmd;
    logic [AW-1:0] mem_addr;
    logic [7:0]    rdata;
    logic          res_valid;
    logic          res_ready;
    rsp_t          res;

    logic          rsp_valid_reg;
    rsp_t          rsp_reg;

    pmat_seq #(
        .OFFSET_BITS    (OFFSET_BITS),
        .NUM_PAGES      (NUM_PAGES),
        .TABLE_PTR_BASE (TABLE_PTR_BASE),
        .AW             (AW)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .cmd       (cmd),
        .mem_addr  (mem_addr),
        .rdata     (rdata)
    );

    pmat_ram #(
        .DEPTH (MEM_BYTES),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .cmd   (cmd),
        .addr  (mem_addr),
        .rdata (rdata)
    );

    assign res_ready = !rsp_valid_reg || rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res_valid && res_ready)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            rsp_reg <= res;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
